### design/easing_curve_interpolator_assert.svh
// Assertion macros for the easing-curve interpolator.
// Included by the top level; no other dependencies.
`ifndef EASING_CURVE_INTERPOLATOR_ASSERT_SVH
`define EASING_CURVE_INTERPOLATOR_ASSERT_SVH

// Check a condition in the same cycle as its antecedent.
`define ECI_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check a condition in the cycle after its antecedent.
`define ECI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/eci_pkg.sv
// Constants, register codes and elaboration-time helpers for the easing-curve interpolator.
// No dependencies.
package eci_pkg;

  localparam int unsigned ECI_FRAC_BITS = 16;

  // Q2.30 fixed-point landmarks
  localparam logic [31:0] Q_ONE  = 32'h4000_0000;
  localparam logic [31:0] Q_HALF = 32'h2000_0000;
  localparam logic [31:0] Q_TWO  = 32'h8000_0000;

  // Divider, square-root and exponential step counts
  localparam int unsigned DIV_STEPS = 62;
  localparam int unsigned SQRT_STEPS = 31;
  localparam int unsigned EXP_STEPS = 30;

  // Configuration register indexes
  localparam logic [1:0] REG_CURVE_SHAPE = 2'd0;
  localparam logic [1:0] REG_EASING_MODE = 2'd1;
  localparam logic [1:0] REG_LOOP_MODE   = 2'd2;
  localparam logic [1:0] REG_SPAN_LENGTH = 2'd3;

  // Curve shapes
  localparam logic [2:0] SHAPE_LINEAR = 3'd0;
  localparam logic [2:0] SHAPE_QUAD   = 3'd1;
  localparam logic [2:0] SHAPE_CUBIC  = 3'd2;
  localparam logic [2:0] SHAPE_CIRC   = 3'd3;
  localparam logic [2:0] SHAPE_EXPO   = 3'd4;

  // Easing modes
  localparam logic [1:0] EASE_IN     = 2'd0;
  localparam logic [1:0] EASE_OUT    = 2'd1;
  localparam logic [1:0] EASE_IN_OUT = 2'd2;
  localparam logic [1:0] EASE_MIDDLE = 2'd3;

  // Loop modes
  localparam logic [1:0] LOOP_CLAMP  = 2'd0;
  localparam logic [1:0] LOOP_WRAP   = 2'd1;
  localparam logic [1:0] LOOP_MIRROR = 2'd2;

  // Floor integer square root; used only at elaboration
  function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] bitv;
    v = v_in;
    res = 64'd0;
    bitv = 64'd1 << 62;
    for (int i = 0; i < 32; i++) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Factor 2^(-2^-idx) in Q30, built by repeated floor square roots of 0.5
  function automatic logic [30:0] exp_coef(input int unsigned idx);
    logic [63:0] c;
    c = {32'd0, Q_HALF};
    for (int unsigned i = 1; i <= idx; i++) begin
      c = isqrt64(c << 30);
    end
    return c[30:0];
  endfunction

endpackage

### design/easing_curve_interpolator.sv
// Easing-curve interpolator: pipelined divider, phase folding, curve units and scaling.
// Depends on eci_pkg and easing_curve_interpolator_assert.svh.
//
// Usage:
//   in_*  : stream request carrying sample_time, from_position and to_position.
//   out_* : stream request carrying eased_position (signed Q16.16, saturated).
//   cfg_* : register write port; cfg_index selects curve_shape, easing_mode,
//           loop_mode or span_length. Write only while the pipeline is empty.
//   Throughput is one request per clock. Registers run from the capture stage
//   through the 62-step restoring divider (one quotient bit per stage), the
//   phase, argument, square and 31-step square-root / exponential product
//   chain (each step one register stage) to the weight, product and output.
//   All stages advance together; when the receiver stalls with a result held,
//   the whole pipeline holds and in_tready drops, so nothing is lost or repeated.
//   Reset clears all valid bits and sets curve linear, mode in, loop clamp and
//   span 1.0.
`include "easing_curve_interpolator_assert.svh"

module easing_curve_interpolator
  import eci_pkg::*;
#(
  parameter int unsigned FRAC_BITS = ECI_FRAC_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [95:0] in_tdata,   // [31:0] sample_time, [63:32] from_position, [95:64] to_position
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] eased_position
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  typedef struct packed {
    logic        vld;
    logic        neg;
    logic [31:0] mag;
    logic [30:0] rem;
    logic [30:0] q;
    logic        ovf;
    logic [31:0] from;
    logic [31:0] to;
  } div_t;

  typedef struct packed {
    logic        vld;
    logic [30:0] n;
    logic [31:0] from;
    logic [31:0] to;
  } ph_t;

  typedef struct packed {
    logic        vld;
    logic        nlow;
    logic [30:0] a;
    logic [30:0] sq;
    logic [30:0] cube;
    logic [3:0]  k;
    logic [29:0] r;
    logic [61:0] sv;
    logic [61:0] sr;
    logic [30:0] er;
    logic [31:0] from;
    logic [31:0] to;
  } crv_t;

  typedef struct packed {
    logic               vld;
    logic [30:0]        w;
    logic signed [32:0] diff;
    logic [31:0]        from;
  } fw_t;

  typedef struct packed {
    logic               vld;
    logic signed [63:0] prod;
    logic [31:0]        from;
  } mp_t;

  logic [2:0]  curve_shape_r;
  logic [1:0]  easing_mode_r;
  logic [1:0]  loop_mode_r;
  logic [30:0] span_length_r;
  logic [30:0] span_eff;
  logic        adv;

  div_t div_r [DIV_STEPS+1];
  ph_t  ph_r;
  ph_t  ph_nxt;
  crv_t xa_r;
  crv_t xa_nxt;
  crv_t c0_r;
  crv_t c0_nxt;
  crv_t it_r [SQRT_STEPS+1];
  fw_t  fw_r;
  fw_t  fw_nxt;
  mp_t  mp_r;
  logic        out_vld_r;
  logic [31:0] out_r;
  logic [31:0] out_nxt;

  // Advance the whole pipeline unless a held result is stalled
  assign adv       = !out_vld_r || out_tready;
  assign in_tready = adv;
  assign cfg_ready = 1'b1;
  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_r;
  assign span_eff  = (span_length_r == 31'd0) ? 31'd1 : span_length_r;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      curve_shape_r <= SHAPE_LINEAR;
      easing_mode_r <= EASE_IN;
      loop_mode_r   <= LOOP_CLAMP;
      span_length_r <= 31'(64'd1 << FRAC_BITS);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_CURVE_SHAPE: curve_shape_r <= cfg_data[2:0];
        REG_EASING_MODE: easing_mode_r <= cfg_data[1:0];
        REG_LOOP_MODE:   loop_mode_r   <= cfg_data[1:0];
        REG_SPAN_LENGTH: span_length_r <= cfg_data[30:0];
      endcase
    end
  end

  // Capture request and take magnitude of time
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_r[0].vld <= 1'b0;
    end else if (adv) begin
      div_r[0].vld  <= in_tvalid;
      div_r[0].neg  <= in_tdata[31];
      div_r[0].mag  <= in_tdata[31] ? 32'(-in_tdata[31:0]) : in_tdata[31:0];
      div_r[0].rem  <= 31'd0;
      div_r[0].q    <= 31'd0;
      div_r[0].ovf  <= 1'b0;
      div_r[0].from <= in_tdata[63:32];
      div_r[0].to   <= in_tdata[95:64];
    end
  end

  // Restoring divider: one quotient bit of (mag << 30) / span per stage
  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    localparam int unsigned BPOS = DIV_STEPS - 1 - j;
    logic        bit_in;
    logic [31:0] trial;
    logic        ge;
    div_t        stg_nxt;

    if (BPOS >= 30) begin : g_magbit
      assign bit_in = div_r[j].mag[BPOS-30];
    end else begin : g_zerobit
      assign bit_in = 1'b0;
    end

    always_comb begin
      trial   = {div_r[j].rem, bit_in};
      ge      = trial >= {1'b0, span_eff};
      stg_nxt = div_r[j];
      stg_nxt.rem = ge ? 31'(trial - {1'b0, span_eff}) : trial[30:0];
      stg_nxt.q   = {div_r[j].q[29:0], ge};
      stg_nxt.ovf = div_r[j].ovf | div_r[j].q[30];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        div_r[j+1].vld <= 1'b0;
      end else if (adv) begin
        div_r[j+1] <= stg_nxt;
      end
    end
  end

  // Fold quotient into phase 0..1.0
  always_comb begin
    logic [31:0] m2;
    logic [31:0] big_q;
    m2     = 32'd0;
    big_q  = {1'b0, div_r[DIV_STEPS].q};
    ph_nxt.vld  = div_r[DIV_STEPS].vld;
    ph_nxt.from = div_r[DIV_STEPS].from;
    ph_nxt.to   = div_r[DIV_STEPS].to;
    case (loop_mode_r)
      LOOP_WRAP: begin
        ph_nxt.n = div_r[DIV_STEPS].neg ?
                   31'(Q_ONE - {2'b0, div_r[DIV_STEPS].q[29:0]}) :
                   {1'b0, div_r[DIV_STEPS].q[29:0]};
      end
      LOOP_MIRROR: begin
        m2 = div_r[DIV_STEPS].neg ? Q_TWO - big_q : big_q;
        ph_nxt.n = (m2 > Q_ONE) ? 31'(Q_TWO - m2) : m2[30:0];
      end
      default: begin
        if (div_r[DIV_STEPS].neg) begin
          ph_nxt.n = 31'd0;
        end else if (div_r[DIV_STEPS].ovf || big_q > Q_ONE) begin
          ph_nxt.n = Q_ONE[30:0];
        end else begin
          ph_nxt.n = div_r[DIV_STEPS].q;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r.vld <= 1'b0;
    end else if (adv) begin
      ph_r <= ph_nxt;
    end
  end

  // Map phase to curve argument and take its magnitude
  always_comb begin
    logic signed [32:0] x;
    logic signed [32:0] ns;
    ns = $signed({2'b0, ph_r.n});
    case (easing_mode_r)
      EASE_OUT:    x = ns - $signed({1'b0, Q_ONE});
      EASE_IN_OUT: x = (ph_r.n < Q_HALF[30:0]) ? ns <<< 1 : (ns - $signed({1'b0, Q_ONE})) <<< 1;
      EASE_MIDDLE: x = (ns - $signed({1'b0, Q_HALF})) <<< 1;
      default:     x = ns;
    endcase
    xa_nxt      = '0;
    xa_nxt.vld  = ph_r.vld;
    xa_nxt.nlow = ph_r.n < Q_HALF[30:0];
    xa_nxt.a    = x[32] ? 31'(-x) : x[30:0];
    xa_nxt.from = ph_r.from;
    xa_nxt.to   = ph_r.to;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xa_r.vld <= 1'b0;
    end else if (adv) begin
      xa_r <= xa_nxt;
    end
  end

  // Square and exponent argument
  always_comb begin
    logic [61:0] sq_full;
    logic [33:0] d;
    sq_full = 62'(xa_r.a) * 62'(xa_r.a);
    d       = 34'd10 * 34'(Q_ONE[30:0] - xa_r.a);
    c0_nxt    = xa_r;
    c0_nxt.sq = sq_full[60:30];
    c0_nxt.k  = d[33:30];
    c0_nxt.r  = d[29:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c0_r.vld <= 1'b0;
    end else if (adv) begin
      c0_r <= c0_nxt;
    end
  end

  // Cube, square-root radicand and exponential seed
  always_ff @(posedge clk) begin
    logic [61:0] cube_full;
    cube_full = 62'(c0_r.sq) * 62'(c0_r.a);
    if (!rst_n) begin
      it_r[0].vld <= 1'b0;
    end else if (adv) begin
      it_r[0]      <= c0_r;
      it_r[0].cube <= cube_full[60:30];
      it_r[0].sv   <= {1'b0, 31'(Q_ONE[30:0] - c0_r.sq), 30'd0};
      it_r[0].sr   <= 62'd0;
      it_r[0].er   <= Q_ONE[30:0];
    end
  end

  // Square-root step per stage and exponential factor step in the first EXP_STEPS stages
  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_itr
    localparam logic [61:0] SBIT = 62'd1 << (60 - 2 * j);
    localparam logic [30:0] ECOEF = exp_coef(j + 1);
    crv_t        stg_nxt;
    logic [61:0] trial;
    logic [61:0] eprod;

    always_comb begin
      trial   = it_r[j].sr + SBIT;
      eprod   = 62'd0;
      stg_nxt = it_r[j];
      if (it_r[j].sv >= trial) begin
        stg_nxt.sv = it_r[j].sv - trial;
        stg_nxt.sr = (it_r[j].sr >> 1) + SBIT;
      end else begin
        stg_nxt.sr = it_r[j].sr >> 1;
      end
      if (j < EXP_STEPS) begin
        eprod = 62'(it_r[j].er) * 62'(ECOEF);
        if (it_r[j].r[29 - ((j < EXP_STEPS) ? j : 0)]) begin
          stg_nxt.er = eprod[60:30];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        it_r[j+1].vld <= 1'b0;
      end else if (adv) begin
        it_r[j+1] <= stg_nxt;
      end
    end
  end

  // Select curve value and apply easing to get weight
  always_comb begin
    logic [30:0] v;
    logic [30:0] ehalf;
    crv_t        c;
    c = it_r[SQRT_STEPS];
    case (curve_shape_r)
      SHAPE_QUAD:  v = c.sq;
      SHAPE_CUBIC: v = c.cube;
      SHAPE_CIRC:  v = Q_ONE[30:0] - c.sr[30:0];
      SHAPE_EXPO:  v = c.er >> c.k;
      default:     v = c.a;
    endcase
    ehalf = v >> 1;
    case (easing_mode_r)
      EASE_OUT:    fw_nxt.w = Q_ONE[30:0] - v;
      EASE_IN_OUT: fw_nxt.w = c.nlow ? ehalf : Q_ONE[30:0] - ehalf;
      EASE_MIDDLE: fw_nxt.w = c.nlow ? (Q_ONE[30:0] - v) >> 1 : 31'((32'(v) + Q_ONE) >> 1);
      default:     fw_nxt.w = v;
    endcase
    fw_nxt.vld  = c.vld;
    fw_nxt.diff = $signed({c.to[31], c.to}) - $signed({c.from[31], c.from});
    fw_nxt.from = c.from;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r.vld <= 1'b0;
    end else if (adv) begin
      fw_r <= fw_nxt;
    end
  end

  // Scale span by weight
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mp_r.vld <= 1'b0;
    end else if (adv) begin
      mp_r.vld  <= fw_r.vld;
      mp_r.prod <= 64'($signed({1'b0, fw_r.w})) * 64'(fw_r.diff);
      mp_r.from <= fw_r.from;
    end
  end

  // Add start position and saturate
  always_comb begin
    logic signed [34:0] sum;
    logic signed [33:0] scaled;
    scaled = 34'(mp_r.prod >>> 30);
    sum    = 35'($signed(mp_r.from)) + 35'(scaled);
    if (sum > 35'sh0_7FFF_FFFF) begin
      out_nxt = 32'h7FFF_FFFF;
    end else if (sum < -35'sh0_8000_0000) begin
      out_nxt = 32'h8000_0000;
    end else begin
      out_nxt = sum[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= mp_r.vld;
      out_r     <= out_nxt;
    end
  end

  `ECI_ASSERT_NOW(a_div_rem, div_r[DIV_STEPS].vld, div_r[DIV_STEPS].rem < span_eff, "rem >= span")
  `ECI_ASSERT_NOW(a_phase_range, ph_r.vld, ph_r.n <= Q_ONE[30:0], "phase above one")
  `ECI_ASSERT_NOW(a_weight_range, fw_r.vld, fw_r.w <= Q_ONE[30:0], "weight above one")
  `ECI_ASSERT_NEXT(a_valid_flow, adv && fw_r.vld, mp_r.vld, "product valid lost")

endmodule

### tb/easing_curve_interpolator_test.sv
// Testbench for easing_curve_interpolator: streams requests, predicts each eased position
// in a local fixed-point model and compares results in order. Depends on eci_pkg and the RTL.
`timescale 1ns / 1ps

module easing_curve_interpolator_test
  import eci_pkg::*;
;

  localparam int LATENCY = 100;
  localparam logic [63:0] QONE = 64'h4000_0000;
  localparam logic [63:0] QHALF = 64'h2000_0000;
  localparam logic [63:0] QTWO = 64'h8000_0000;
  localparam logic [63:0] QMASK = 64'h3FFF_FFFF;

  typedef struct packed {
    logic [31:0] to_pos;
    logic [31:0] from_pos;
    logic [31:0] t;
  } sample_t;

  logic clk;
  logic rst_n;
  logic in_tvalid, in_tready;
  logic [95:0] in_tdata;
  logic out_tvalid, out_tready;
  logic [31:0] out_tdata;
  logic cfg_valid, cfg_ready;
  logic [1:0] cfg_index;
  logic [31:0] cfg_data;

  easing_curve_interpolator dut (.*);

  // Local copy of the register settings
  logic [2:0] cur_shape;
  logic [1:0] cur_ease;
  logic [1:0] cur_loop;
  logic [30:0] cur_span;

  sample_t pending_q[$];
  logic [31:0] position_q[$];
  int mismatches;
  bit driver_hold;
  bit in_taken;

  always begin
    clk = 1'b1; #2;
    clk = 1'b0; #2;
  end

  function automatic logic [63:0] floor_sqrt(input logic [63:0] v_in);
    logic [63:0] v, res, b;
    v = v_in;
    res = 0;
    b = 64'd1 << 62;
    while (b > v && b != 0) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // 2^-d in Q30 from a shift and a product of fractional-bit factors
  function automatic logic [63:0] pow2_neg(input logic [63:0] d);
    logic [63:0] k, r, res, c;
    k = d >> 30;
    r = d & QMASK;
    res = QONE;
    c = QHALF;
    for (int i = 1; i <= 30; i++) begin
      c = floor_sqrt(c << 30);
      if (r[30 - i]) res = (res * c) >> 30;
    end
    if (k >= 31) return 0;
    return res >> k;
  endfunction

  function automatic logic [31:0] eased_position(input sample_t s);
    logic signed [63:0] t, from, to, x, diff, prod, scaled, res;
    logic [63:0] mag, span, q, n, m, a, v, w;
    bit neg;
    t = $signed(s.t);
    from = $signed(s.from_pos);
    to = $signed(s.to_pos);
    neg = t < 0;
    mag = neg ? -t : t;
    span = (cur_span == 0) ? 64'd1 : {33'd0, cur_span};
    q = (mag << 30) / span;
    // phase
    if (cur_loop == LOOP_WRAP) begin
      n = neg ? QONE - (q & QMASK) : (q & QMASK);
    end else if (cur_loop == LOOP_MIRROR) begin
      m = q & (QTWO - 1);
      n = neg ? QTWO - m : m;
      if (n > QONE) n = QTWO - n;
    end else begin
      n = neg ? 64'd0 : (q > QONE ? QONE : q);
    end
    // curve argument
    case (cur_ease)
      EASE_OUT:    x = $signed(n) - $signed(QONE);
      EASE_IN_OUT: x = (n < QHALF) ? $signed(n) * 2 : ($signed(n) - $signed(QONE)) * 2;
      EASE_MIDDLE: x = ($signed(n) - $signed(QHALF)) * 2;
      default:     x = $signed(n);
    endcase
    a = (x < 0) ? -x : x;
    case (cur_shape)
      SHAPE_QUAD:  v = (a * a) >> 30;
      SHAPE_CUBIC: v = (((a * a) >> 30) * a) >> 30;
      SHAPE_CIRC:  v = QONE - floor_sqrt((QONE - ((a * a) >> 30)) << 30);
      SHAPE_EXPO:  v = pow2_neg(10 * (QONE - a));
      default:     v = a;
    endcase
    case (cur_ease)
      EASE_OUT:    w = QONE - v;
      EASE_IN_OUT: w = (n < QHALF) ? (v >> 1) : QONE - (v >> 1);
      EASE_MIDDLE: w = (n < QHALF) ? ((QONE - v) >> 1) : ((v + QONE) >> 1);
      default:     w = v;
    endcase
    diff = to - from;
    prod = $signed(w) * diff;
    if (prod >= 0) scaled = prod >>> 30;
    else scaled = -$signed((64'(-prod) + QMASK) >> 30);
    res = from + scaled;
    if (res > 64'sd2147483647) res = 64'sd2147483647;
    if (res < -64'sd2147483648) res = -64'sd2147483648;
    return res[31:0];
  endfunction

  // Note whether the rising edge took the pending request
  always @(posedge clk) begin
    in_taken <= rst_n && in_tvalid && in_tready;
  end

  // Driver: send queued requests in bursts with random gaps
  int burst_left;
  int gap_left;
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      if (in_tvalid && in_taken) begin
        position_q.push_back(eased_position(pending_q.pop_front()));
      end
      if (in_tvalid && !in_taken) begin
        // hold the current request
      end else if (driver_hold || pending_q.size() == 0) begin
        in_tvalid <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
        in_tvalid <= 1'b0;
      end else begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 30);
          if ($urandom_range(0, 3) == 0) gap_left = 0;
          else gap_left = $urandom_range(1, 8);
        end
        burst_left--;
        in_tvalid <= 1'b1;
        in_tdata <= pending_q[0];
      end
    end
  end

  // Receiver stall pattern and result check
  int stall_phase;
  always @(negedge clk) begin
    stall_phase++;
    if (stall_phase % 512 < 128) out_tready <= 1'b1;
    else out_tready <= ($urandom_range(0, 2) != 0);
  end

  always @(posedge clk) begin
    logic [31:0] want;
    if (rst_n && out_tvalid && out_tready) begin
      if (position_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", out_tdata);
      end else begin
        want = position_q.pop_front();
        if (want !== out_tdata) begin
          mismatches++;
          if (mismatches <= 10)
            $display("eased_position mismatch: expected %h actual %h", want, out_tdata);
        end
      end
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      REG_CURVE_SHAPE: cur_shape = val[2:0];
      REG_EASING_MODE: cur_ease = val[1:0];
      REG_LOOP_MODE:   cur_loop = val[1:0];
      default:         cur_span = val[30:0];
    endcase
  endtask

  // Wait until everything queued has been sent and checked
  task automatic drain();
    while (pending_q.size() != 0 || in_tvalid) @(posedge clk);
    @(negedge clk);
    while (position_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return $urandom_range(0, 32'h0003_0000);
      3: return -$urandom_range(0, 32'h0003_0000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] rand_time();
    logic [31:0] r;
    r = $urandom_range(0, 3 * cur_span + 16);
    case ($urandom_range(0, 4))
      0: return -r;
      1: return $urandom;
      default: return r;
    endcase
  endfunction

  initial begin
    sample_t s;
    logic [31:0] spans[6];
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = REG_CURVE_SHAPE;
    cfg_data = '0;
    mismatches = 0;
    driver_hold = 0;
    stall_phase = 0;
    cur_shape = SHAPE_LINEAR;
    cur_ease = EASE_IN;
    cur_loop = LOOP_CLAMP;
    cur_span = 31'h1_0000;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: field extremes, negative time, zero span, exponential at zero
    foreach (spans[i]) spans[i] = 0;
    for (int k = 0; k < 22; k++) begin
      s.t = (k % 4 == 0) ? 32'h8000_0000 : (k % 4 == 1) ? 32'h7FFF_FFFF :
            (k % 4 == 2) ? 32'h0 : 32'hFFFF_8000;
      s.from_pos = (k % 3 == 0) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      s.to_pos = (k % 2 == 0) ? 32'h7FFF_FFFF : 32'h8000_0000;
      if (k >= 12) s.t = k * 32'h2000;
      pending_q.push_back(s);
      if (k % 4 == 3) begin
        drain();
        write_reg(REG_CURVE_SHAPE, (k / 4) % 8);
        write_reg(REG_EASING_MODE, k % 4);
        write_reg(REG_LOOP_MODE, (k / 4) % 4);
        write_reg(REG_SPAN_LENGTH, (k == 7) ? 32'd0 : 32'h1_0000);
      end
    end
    drain();

    // Random phases across all settings; extremes of span included
    spans[0] = 32'd1; spans[1] = 32'h7FFF_FFFF; spans[2] = 32'h1_0000;
    spans[3] = 32'd0; spans[4] = 32'h0000_4000; spans[5] = 32'hFFFF_FFFF;
    for (int ph = 0; ph < 40; ph++) begin
      write_reg(REG_CURVE_SHAPE, (ph < 32) ? ph % 5 : $urandom_range(0, 7));
      write_reg(REG_EASING_MODE, (ph / 5) % 4);
      write_reg(REG_LOOP_MODE, $urandom_range(0, 3));
      write_reg(REG_SPAN_LENGTH,
                ($urandom_range(0, 2) == 0) ? spans[$urandom_range(0, 5)] : $urandom);
      for (int k = 0; k < 10; k++) begin
        s.t = rand_time();
        s.from_pos = rand_word();
        s.to_pos = rand_word();
        pending_q.push_back(s);
      end
      // pause until the pipeline empties once mid-phase
      if (ph == 20) begin
        while (pending_q.size() > 5) @(posedge clk);
        driver_hold = 1;
        while (in_tvalid) @(posedge clk);
        while (position_q.size() != 0) @(posedge clk);
        driver_hold = 0;
      end
      drain();
      repeat (LATENCY + 10) @(posedge clk);
    end
    repeat (LATENCY + 10) @(posedge clk);
    if (mismatches == 0 && position_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

### filelist.f
+incdir+design
design/eci_pkg.sv
design/easing_curve_interpolator.sv
tb/easing_curve_interpolator_test.sv
